FILE: rtl/core/roi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ray and oriented box intersection unit.
package roi_pkg;

	localparam int QBITS     = 34;
	localparam int NUM_W     = 64;
	localparam int DEN_W     = 32;
	localparam int REM_W     = NUM_W + 2;
	localparam int LANES     = 4;
	localparam int LANE_X_LO = 0;
	localparam int LANE_X_HI = 1;
	localparam int LANE_Y_LO = 2;
	localparam int LANE_Y_HI = 3;

	localparam logic [14:0] EPS_RESET = 15'd1;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [30:0]        max_distance;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [15:0] right_axis_x;
		logic signed [15:0] right_axis_y;
		logic [30:0]        half_width;
		logic [30:0]        half_height;
	} item_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] right_axis_x;
		logic signed [15:0] right_axis_y;
		logic [30:0]        max_distance;
		logic [44:0]        hwq;
		logic [44:0]        hhq;
		logic signed [49:0] lox;
		logic signed [49:0] loy;
		logic signed [32:0] ldx;
		logic signed [32:0] ldy;
		logic               par_x;
		logic               par_y;
		logic               rej_x;
		logic               rej_y;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             neg;
	} div_op_t;

	typedef struct packed {
		logic [QBITS-1:0] q;
		logic             sat;
		logic             neg;
	} div_res_t;

	typedef struct packed {
		side_t       side;
		logic        hit;
		logic [30:0] t;
	} slab_res_t;

	typedef struct packed {
		logic               hit;
		logic [30:0]        distance;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
	} result_t;

endpackage

FILE: rtl/core/roi_if.sv
`timescale 1ns / 1ps
// Handshake channels for ray and box items and for intersection results.
interface roi_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic [30:0]        max_distance;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic signed [15:0] right_axis_x;
	logic signed [15:0] right_axis_y;
	logic [30:0]        half_width;
	logic [30:0]        half_height;

	modport source(output valid, output origin_x, output origin_y, output dir_x, output dir_y,
		output max_distance, output center_x, output center_y, output right_axis_x,
		output right_axis_y, output half_width, output half_height, input ready);
	modport sink(input valid, input origin_x, input origin_y, input dir_x, input dir_y,
		input max_distance, input center_x, input center_y, input right_axis_x,
		input right_axis_y, input half_width, input half_height, output ready);
endinterface

interface roi_out_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [30:0]        distance;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;

	modport source(output valid, output hit, output distance, output point_x, output point_y,
		output normal_x, output normal_y, input ready);
	modport sink(input valid, input hit, input distance, input point_x, input point_y,
		input normal_x, input normal_y, output ready);
endinterface

FILE: rtl/core/ray_obb_intersect_2d_unit.sv
`timescale 1ns / 1ps
// Ray against oriented box slab test, fully pipelined: one item per cycle while
// input ready is high. The 35 stage divider pipeline sets the depth.
// A two entry output buffer keeps input ready high while one result waits.
// Reset clears all valid bits and sets direction_epsilon to 1.
module ray_obb_intersect_2d_unit (
	input  logic             clk,
	input  logic             arst_n,
	roi_in_if.sink           ray_box,
	roi_out_if.source        result,
	input  logic             cfg_we,
	input  logic [14:0]      cfg_wdata
);

	logic [14:0]              eps_q;
	logic                     en;
	roi_pkg::item_t           item;
	logic                     xf_valid, dv_valid, sl_valid, hp_valid;
	roi_pkg::side_t           xf_side, dv_side;
	roi_pkg::div_op_t         xf_ops [roi_pkg::LANES];
	roi_pkg::div_res_t        dv_res [roi_pkg::LANES];
	roi_pkg::slab_res_t       sl_res;
	roi_pkg::result_t         hp_res;
	logic                     out_v_q, skid_v_q, take, arrive;
	roi_pkg::result_t         out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= roi_pkg::EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	assign en            = !skid_v_q;
	assign ray_box.ready = en;

	always_comb begin
		item.origin_x     = ray_box.origin_x;
		item.origin_y     = ray_box.origin_y;
		item.dir_x        = ray_box.dir_x;
		item.dir_y        = ray_box.dir_y;
		item.max_distance = ray_box.max_distance;
		item.center_x     = ray_box.center_x;
		item.center_y     = ray_box.center_y;
		item.right_axis_x = ray_box.right_axis_x;
		item.right_axis_y = ray_box.right_axis_y;
		item.half_width   = ray_box.half_width;
		item.half_height  = ray_box.half_height;
	end

	roi_xform u_xform (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.item_valid (ray_box.valid),
		.item       (item),
		.eps        (eps_q),
		.valid      (xf_valid),
		.side       (xf_side),
		.ops        (xf_ops)
	);

	roi_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (xf_valid),
		.in_side  (xf_side),
		.ops      (xf_ops),
		.valid    (dv_valid),
		.side     (dv_side),
		.res      (dv_res)
	);

	roi_slab u_slab (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (dv_valid),
		.in_side  (dv_side),
		.res      (dv_res),
		.valid    (sl_valid),
		.out_res  (sl_res)
	);

	roi_hitpt u_hitpt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sl_valid),
		.in_res   (sl_res),
		.valid    (hp_valid),
		.result   (hp_res)
	);

	assign take   = out_v_q && result.ready;
	assign arrive = en && hp_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || take) begin
			out_v_q  <= skid_v_q || arrive;
			skid_v_q <= 1'b0;
		end else if (arrive) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || take) begin
			out_q <= skid_v_q ? skid_q : hp_res;
		end else if (arrive) begin
			skid_q <= hp_res;
		end
	end

	assign result.valid    = out_v_q;
	assign result.hit      = out_q.hit;
	assign result.distance = out_q.distance;
	assign result.point_x  = out_q.point_x;
	assign result.point_y  = out_q.point_y;
	assign result.normal_x = out_q.normal_x;
	assign result.normal_y = out_q.normal_y;

endmodule

FILE: rtl/core/roi_xform.sv
`timescale 1ns / 1ps
// Front stages: box frame transform, slab numerators, divisors and parallel flags.
module roi_xform (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    item_valid,
	input  roi_pkg::item_t          item,
	input  logic [14:0]             eps,
	output logic                    valid,
	output roi_pkg::side_t          side,
	output roi_pkg::div_op_t        ops [roi_pkg::LANES]
);

	logic                 v_s1, v_s2, v_s3, v_s4;
	roi_pkg::item_t       item_s1, item_s2, item_s3;
	logic signed [32:0]   relx_s1, rely_s1;
	logic signed [48:0]   pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [31:0]   pe_s2, pf_s2, pg_s2, ph_s2;
	logic signed [49:0]   lox_s3, loy_s3;
	logic signed [32:0]   ldx_s3, ldy_s3;
	roi_pkg::side_t       side_s4;
	roi_pkg::div_op_t     ops_s4 [roi_pkg::LANES];

	logic signed [45:0]   hws, hhs;
	logic signed [50:0]   dxl, dxh, dyl, dyh;
	logic [49:0]          axl, axh, ayl, ayh;
	logic [31:0]          adx, ady;
	logic [28:0]          eps_q30;
	roi_pkg::side_t       side_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item;
			relx_s1 <= 33'($signed(item.origin_x)) - 33'($signed(item.center_x));
			rely_s1 <= 33'($signed(item.origin_y)) - 33'($signed(item.center_y));

			item_s2 <= item_s1;
			pa_s2   <= $signed(relx_s1) * $signed(item_s1.right_axis_x);
			pb_s2   <= $signed(rely_s1) * $signed(item_s1.right_axis_y);
			pc_s2   <= $signed(rely_s1) * $signed(item_s1.right_axis_x);
			pd_s2   <= $signed(relx_s1) * $signed(item_s1.right_axis_y);
			pe_s2   <= $signed(item_s1.dir_x) * $signed(item_s1.right_axis_x);
			pf_s2   <= $signed(item_s1.dir_y) * $signed(item_s1.right_axis_y);
			pg_s2   <= $signed(item_s1.dir_y) * $signed(item_s1.right_axis_x);
			ph_s2   <= $signed(item_s1.dir_x) * $signed(item_s1.right_axis_y);

			item_s3 <= item_s2;
			lox_s3  <= 50'(pa_s2) + 50'(pb_s2);
			loy_s3  <= 50'(pc_s2) - 50'(pd_s2);
			ldx_s3  <= 33'(pe_s2) + 33'(pf_s2);
			ldy_s3  <= 33'(pg_s2) - 33'(ph_s2);

			side_s4 <= side_c;
			ops_s4[roi_pkg::LANE_X_LO] <= '{num: {axl, 14'b0}, den: adx,
				neg: dxl[50] ^ ldx_s3[32]};
			ops_s4[roi_pkg::LANE_X_HI] <= '{num: {axh, 14'b0}, den: adx,
				neg: dxh[50] ^ ldx_s3[32]};
			ops_s4[roi_pkg::LANE_Y_LO] <= '{num: {ayl, 14'b0}, den: ady,
				neg: dyl[50] ^ ldy_s3[32]};
			ops_s4[roi_pkg::LANE_Y_HI] <= '{num: {ayh, 14'b0}, den: ady,
				neg: dyh[50] ^ ldy_s3[32]};
		end
	end

	always_comb begin
		hws     = $signed({1'b0, item_s3.half_width, 14'b0});
		hhs     = $signed({1'b0, item_s3.half_height, 14'b0});
		dxl     = -51'(hws) - 51'(lox_s3);
		dxh     = 51'(hws) - 51'(lox_s3);
		dyl     = -51'(hhs) - 51'(loy_s3);
		dyh     = 51'(hhs) - 51'(loy_s3);
		axl     = dxl[50] ? 50'(-dxl) : dxl[49:0];
		axh     = dxh[50] ? 50'(-dxh) : dxh[49:0];
		ayl     = dyl[50] ? 50'(-dyl) : dyl[49:0];
		ayh     = dyh[50] ? 50'(-dyh) : dyh[49:0];
		adx     = ldx_s3[32] ? 32'(-ldx_s3) : ldx_s3[31:0];
		ady     = ldy_s3[32] ? 32'(-ldy_s3) : ldy_s3[31:0];
		eps_q30 = {eps, 14'b0};

		side_c.origin_x     = item_s3.origin_x;
		side_c.origin_y     = item_s3.origin_y;
		side_c.dir_x        = item_s3.dir_x;
		side_c.dir_y        = item_s3.dir_y;
		side_c.right_axis_x = item_s3.right_axis_x;
		side_c.right_axis_y = item_s3.right_axis_y;
		side_c.max_distance = item_s3.max_distance;
		side_c.hwq          = {item_s3.half_width, 14'b0};
		side_c.hhq          = {item_s3.half_height, 14'b0};
		side_c.lox          = lox_s3;
		side_c.loy          = loy_s3;
		side_c.ldx          = ldx_s3;
		side_c.ldy          = ldy_s3;
		side_c.par_x        = (ldx_s3 == 33'sd0) || (adx < 32'(eps_q30));
		side_c.par_y        = (ldy_s3 == 33'sd0) || (ady < 32'(eps_q30));
		side_c.rej_x        = (lox_s3 < 50'(-hws)) || (lox_s3 > 50'(hws));
		side_c.rej_y        = (loy_s3 < 50'(-hhs)) || (loy_s3 > 50'(hhs));
	end

	assign valid = v_s4;
	assign side  = side_s4;
	assign ops   = ops_s4;

endmodule

FILE: rtl/core/roi_divide.sv
`timescale 1ns / 1ps
// Four-lane restoring divider pipeline, one quotient bit per stage, with overflow check.
module roi_divide (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  roi_pkg::side_t        in_side,
	input  roi_pkg::div_op_t      ops [roi_pkg::LANES],
	output logic                  valid,
	output roi_pkg::side_t        side,
	output roi_pkg::div_res_t     res [roi_pkg::LANES]
);

	localparam int NS = roi_pkg::QBITS + 1;

	logic                       v_s    [NS];
	roi_pkg::side_t             side_s [NS];
	logic [roi_pkg::REM_W-1:0]  rem_s  [NS][roi_pkg::LANES];
	logic [roi_pkg::DEN_W-1:0]  den_s  [NS][roi_pkg::LANES];
	logic [roi_pkg::QBITS-1:0]  q_s    [NS][roi_pkg::LANES];
	logic                       sat_s  [NS][roi_pkg::LANES];
	logic                       neg_s  [NS][roi_pkg::LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int l = 0; l < roi_pkg::LANES; l++) begin
				rem_s[0][l] <= roi_pkg::REM_W'(ops[l].num);
				den_s[0][l] <= ops[l].den;
				q_s[0][l]   <= '0;
				neg_s[0][l] <= ops[l].neg;
				sat_s[0][l] <= roi_pkg::REM_W'(ops[l].num) >=
					{ops[l].den, {roi_pkg::QBITS{1'b0}}};
			end
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_stage
		logic [roi_pkg::REM_W-1:0] dsh [roi_pkg::LANES];
		logic                      ge  [roi_pkg::LANES];
		logic [roi_pkg::QBITS-1:0] qn  [roi_pkg::LANES];

		always_comb begin
			for (int l = 0; l < roi_pkg::LANES; l++) begin
				dsh[l] = roi_pkg::REM_W'(den_s[k-1][l]) << (roi_pkg::QBITS - k);
				ge[l]  = rem_s[k-1][l] >= dsh[l];
				qn[l]  = q_s[k-1][l] |
					(roi_pkg::QBITS'(ge[l]) << (roi_pkg::QBITS - k));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_s[k-1];
				for (int l = 0; l < roi_pkg::LANES; l++) begin
					rem_s[k][l] <= ge[l] ? rem_s[k-1][l] - dsh[l] : rem_s[k-1][l];
					den_s[k][l] <= den_s[k-1][l];
					sat_s[k][l] <= sat_s[k-1][l];
					neg_s[k][l] <= neg_s[k-1][l];
					q_s[k][l]   <= qn[l];
				end
			end
		end
	end

	assign valid = v_s[NS-1];
	assign side  = side_s[NS-1];

	always_comb begin
		for (int l = 0; l < roi_pkg::LANES; l++) begin
			res[l].q   = q_s[NS-1][l];
			res[l].sat = sat_s[NS-1][l];
			res[l].neg = neg_s[NS-1][l];
		end
	end

endmodule

FILE: rtl/core/roi_slab.sv
`timescale 1ns / 1ps
// Slab stages: signed saturated distances, interval sort, clip against both axes.
module roi_slab (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  roi_pkg::side_t        in_side,
	input  roi_pkg::div_res_t     res [roi_pkg::LANES],
	output logic                  valid,
	output roi_pkg::slab_res_t    out_res
);

	localparam logic [roi_pkg::QBITS-1:0] TSAT = roi_pkg::QBITS'(64'h1_0000_0000);

	logic               v_s1, v_s2, v_s3, v_s4;
	roi_pkg::side_t     side_s1, side_s2, side_s3;
	logic signed [33:0] t_s1 [roi_pkg::LANES];
	logic signed [33:0] lox_s2, hix_s2, loy_s2, hiy_s2;
	logic signed [33:0] tmin_s3, tmax_s3;
	logic               ok_s3;
	roi_pkg::slab_res_t res_s4;

	logic [roi_pkg::QBITS-1:0] mag [roi_pkg::LANES];
	logic signed [33:0]        maxd, lx, hx, ly, hy, a, b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		for (int l = 0; l < roi_pkg::LANES; l++) begin
			mag[l] = (res[l].sat || res[l].q > TSAT) ? TSAT : res[l].q;
		end
		maxd = $signed({3'b0, side_s1.max_distance});
		lx   = (t_s1[roi_pkg::LANE_X_LO] < t_s1[roi_pkg::LANE_X_HI]) ?
			t_s1[roi_pkg::LANE_X_LO] : t_s1[roi_pkg::LANE_X_HI];
		hx   = (t_s1[roi_pkg::LANE_X_LO] < t_s1[roi_pkg::LANE_X_HI]) ?
			t_s1[roi_pkg::LANE_X_HI] : t_s1[roi_pkg::LANE_X_LO];
		ly   = (t_s1[roi_pkg::LANE_Y_LO] < t_s1[roi_pkg::LANE_Y_HI]) ?
			t_s1[roi_pkg::LANE_Y_LO] : t_s1[roi_pkg::LANE_Y_HI];
		hy   = (t_s1[roi_pkg::LANE_Y_LO] < t_s1[roi_pkg::LANE_Y_HI]) ?
			t_s1[roi_pkg::LANE_Y_HI] : t_s1[roi_pkg::LANE_Y_LO];
		a    = (lox_s2 > 34'sd0) ? lox_s2 : 34'sd0;
		b    = (hix_s2 < $signed({3'b0, side_s2.max_distance})) ?
			hix_s2 : $signed({3'b0, side_s2.max_distance});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			for (int l = 0; l < roi_pkg::LANES; l++) begin
				t_s1[l] <= res[l].neg ? -$signed(mag[l]) : $signed(mag[l]);
			end

			side_s2 <= side_s1;
			lox_s2  <= side_s1.par_x ? 34'sd0 : lx;
			hix_s2  <= side_s1.par_x ? maxd : hx;
			loy_s2  <= side_s1.par_y ? 34'sd0 : ly;
			hiy_s2  <= side_s1.par_y ? maxd : hy;

			side_s3 <= side_s2;
			tmin_s3 <= (loy_s2 > a) ? loy_s2 : a;
			tmax_s3 <= (hiy_s2 < b) ? hiy_s2 : b;
			ok_s3   <= !(side_s2.par_x && side_s2.rej_x) && !(side_s2.par_y && side_s2.rej_y);

			res_s4.side <= side_s3;
			res_s4.hit  <= ok_s3 && (tmin_s3 <= tmax_s3);
			res_s4.t    <= tmin_s3[30:0];
		end
	end

	assign valid   = v_s4;
	assign out_res = res_s4;

endmodule

FILE: rtl/core/roi_hitpt.sv
`timescale 1ns / 1ps
// Back stages: world hit point, local hit point, nearest face and result assembly.
module roi_hitpt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  roi_pkg::slab_res_t    in_res,
	output logic                  valid,
	output roi_pkg::result_t      result
);

	logic               v_s1, v_s2, v_s3, v_s4;
	roi_pkg::slab_res_t r_s1, r_s2, r_s3;
	logic signed [47:0] pdx_s1, pdy_s1;
	logic signed [64:0] plx_s1, ply_s1;
	logic signed [35:0] px_s2, py_s2;
	logic signed [52:0] hx_s2, hy_s2;
	logic signed [31:0] px_s3, py_s3;
	logic [53:0]        dpx_s3, dnx_s3, dpy_s3, dny_s3;
	roi_pkg::result_t   res_s4;

	logic signed [31:0] ts;
	logic signed [48:0] rdx, rdy;
	logic signed [65:0] rlx, rly;
	logic signed [45:0] hws, hhs;
	logic signed [53:0] ex1, ex2, ey1, ey2;
	logic signed [15:0] rx, ry, nx, ny;
	logic [53:0]        best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	function automatic logic signed [31:0] clamp32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [53:0] abs54(input logic signed [53:0] v);
		return v[53] ? 54'(-v) : 54'(v);
	endfunction

	always_comb begin
		ts  = $signed({1'b0, in_res.t});
		rdx = 49'(pdx_s1) + 49'sd8192;
		rdy = 49'(pdy_s1) + 49'sd8192;
		rlx = 66'(plx_s1) + 66'sd8192;
		rly = 66'(ply_s1) + 66'sd8192;
		hws = $signed({1'b0, r_s2.side.hwq});
		hhs = $signed({1'b0, r_s2.side.hhq});
		ex1 = 54'(hx_s2) - 54'(hws);
		ex2 = 54'(hx_s2) + 54'(hws);
		ey1 = 54'(hy_s2) - 54'(hhs);
		ey2 = 54'(hy_s2) + 54'(hhs);

		rx   = r_s3.side.right_axis_x;
		ry   = r_s3.side.right_axis_y;
		best = dpx_s3;
		nx   = rx;
		ny   = ry;
		if (dnx_s3 < best) begin
			best = dnx_s3;
			nx   = 16'(-rx);
			ny   = 16'(-ry);
		end
		if (dpy_s3 < best) begin
			best = dpy_s3;
			nx   = 16'(-ry);
			ny   = rx;
		end
		if (dny_s3 < best) begin
			nx = ry;
			ny = 16'(-rx);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= in_res;
			pdx_s1 <= $signed(in_res.side.dir_x) * ts;
			pdy_s1 <= $signed(in_res.side.dir_y) * ts;
			plx_s1 <= $signed(in_res.side.ldx) * ts;
			ply_s1 <= $signed(in_res.side.ldy) * ts;

			r_s2  <= r_s1;
			px_s2 <= 36'($signed(r_s1.side.origin_x)) + 36'($signed(rdx[48:14]));
			py_s2 <= 36'($signed(r_s1.side.origin_y)) + 36'($signed(rdy[48:14]));
			hx_s2 <= 53'($signed(r_s1.side.lox)) + 53'($signed(rlx[65:14]));
			hy_s2 <= 53'($signed(r_s1.side.loy)) + 53'($signed(rly[65:14]));

			r_s3   <= r_s2;
			px_s3  <= clamp32(px_s2);
			py_s3  <= clamp32(py_s2);
			dpx_s3 <= abs54(ex1);
			dnx_s3 <= abs54(ex2);
			dpy_s3 <= abs54(ey1);
			dny_s3 <= abs54(ey2);

			if (r_s3.hit) begin
				res_s4.hit      <= 1'b1;
				res_s4.distance <= r_s3.t;
				res_s4.point_x  <= px_s3;
				res_s4.point_y  <= py_s3;
				res_s4.normal_x <= nx;
				res_s4.normal_y <= ny;
			end else begin
				res_s4 <= '0;
			end
		end
	end

	assign valid  = v_s4;
	assign result = res_s4;

endmodule

FILE: rtl/core/roi_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the intersection unit and its bind to the top level.
module roi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               hit,
	input logic [30:0]        distance,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({hit, distance, point_x, point_y, normal_x, normal_y}))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> distance == 31'd0 && point_x == 32'sd0 &&
		point_y == 32'sd0 && normal_x == 16'sd0 && normal_y == 16'sd0)
		else $error("miss result carries nonzero fields");

	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("input stalled without a blocked output transfer");

endmodule

bind ray_obb_intersect_2d_unit roi_checker u_roi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (ray_box.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.hit       (result.hit),
	.distance  (result.distance),
	.point_x   (result.point_x),
	.point_y   (result.point_y),
	.normal_x  (result.normal_x),
	.normal_y  (result.normal_y)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the ray against oriented box intersection unit.
module testbench;

	class ray_box_scoreboard;
		roi_pkg::result_t pending[$];
		logic [14:0]      epsilon;
		int               mismatches;

		function new();
			epsilon = roi_pkg::EPS_RESET;
			mismatches = 0;
		endfunction

		function bit slab(longint lo, longint ld, longint h, longint eps,
				inout longint tmin, inout longint tmax);
			logic signed [127:0] n1, n2, q1, q2;
			longint t1, t2, tmp;
			if (ld == 0 || (ld < 0 ? -ld : ld) < eps)
				return !(lo < -h || lo > h);
			n1 = -h - lo;
			n2 = h - lo;
			q1 = (n1 * 16384) / ld;
			q2 = (n2 * 16384) / ld;
			if (q1 > (128'sd1 <<< 32)) q1 = 128'sd1 <<< 32;
			if (q1 < -(128'sd1 <<< 32)) q1 = -(128'sd1 <<< 32);
			if (q2 > (128'sd1 <<< 32)) q2 = 128'sd1 <<< 32;
			if (q2 < -(128'sd1 <<< 32)) q2 = -(128'sd1 <<< 32);
			t1 = longint'(q1);
			t2 = longint'(q2);
			if (t1 > t2) begin
				tmp = t1; t1 = t2; t2 = tmp;
			end
			if (t1 > tmin) tmin = t1;
			if (t2 < tmax) tmax = t2;
			return tmin <= tmax;
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function void note_item(roi_pkg::item_t it);
			longint ox, oy, dx, dy, rx, ry, hw, hh, eps, relx, rely;
			longint lox, loy, ldx, ldy, tmin, tmax, hx, hy, best, d;
			roi_pkg::result_t r;
			ox = it.origin_x; oy = it.origin_y;
			dx = it.dir_x; dy = it.dir_y;
			rx = it.right_axis_x; ry = it.right_axis_y;
			hw = longint'(it.half_width) << 14;
			hh = longint'(it.half_height) << 14;
			eps = longint'(epsilon) << 14;
			relx = ox - longint'(it.center_x);
			rely = oy - longint'(it.center_y);
			lox = relx * rx + rely * ry;
			loy = rely * rx - relx * ry;
			ldx = dx * rx + dy * ry;
			ldy = dy * rx - dx * ry;
			tmin = 0;
			tmax = it.max_distance;
			r = '0;
			if (slab(lox, ldx, hw, eps, tmin, tmax) && slab(loy, ldy, hh, eps, tmin, tmax)) begin
				r.hit = 1'b1;
				r.distance = tmin[30:0];
				r.point_x = 32'(sat32(ox + ((dx * tmin + 8192) >>> 14)));
				r.point_y = 32'(sat32(oy + ((dy * tmin + 8192) >>> 14)));
				hx = lox + ((ldx * tmin + 8192) >>> 14);
				hy = loy + ((ldy * tmin + 8192) >>> 14);
				best = hx - hw; if (best < 0) best = -best;
				r.normal_x = it.right_axis_x;
				r.normal_y = it.right_axis_y;
				d = hx + hw; if (d < 0) d = -d;
				if (d < best) begin
					best = d;
					r.normal_x = -it.right_axis_x;
					r.normal_y = -it.right_axis_y;
				end
				d = hy - hh; if (d < 0) d = -d;
				if (d < best) begin
					best = d;
					r.normal_x = -it.right_axis_y;
					r.normal_y = it.right_axis_x;
				end
				d = hy + hh; if (d < 0) d = -d;
				if (d < best) begin
					r.normal_x = it.right_axis_y;
					r.normal_y = -it.right_axis_x;
				end
			end
			pending = {pending, r};
		endfunction

		function void check_result(roi_pkg::result_t got);
			roi_pkg::result_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result transfer with nothing outstanding: %p", got);
				return;
			end
			exp = pending.pop_front();
			if (got.hit !== exp.hit || got.distance !== exp.distance
					|| got.point_x !== exp.point_x || got.point_y !== exp.point_y
					|| got.normal_x !== exp.normal_x || got.normal_y !== exp.normal_y) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected %p, actual %p", exp, got);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;
	int          send_idle = 0;
	int          recv_stall = 0;
	int          quiet_cycles = 0;
	ray_box_scoreboard sb = new();

	roi_in_if  ray_box();
	roi_out_if result();

	ray_obb_intersect_2d_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.ray_box(ray_box.source),
		.result(result.sink),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	initial begin
		ray_box.valid = 1'b0;
		{ray_box.origin_x, ray_box.origin_y, ray_box.dir_x, ray_box.dir_y,
			ray_box.max_distance, ray_box.center_x, ray_box.center_y,
			ray_box.right_axis_x, ray_box.right_axis_y, ray_box.half_width,
			ray_box.half_height} = '0;
		result.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready)
				sb.check_result(roi_pkg::result_t'{result.hit, result.distance,
					result.point_x, result.point_y, result.normal_x, result.normal_y});
			result.ready <= ($urandom_range(99) >= recv_stall);
			if ((result.valid && result.ready) || (ray_box.valid && ray_box.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= 5000) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_item(roi_pkg::item_t it);
		while ($urandom_range(99) < send_idle) begin
			ray_box.valid <= 1'b0;
			@(posedge clk);
		end
		ray_box.valid <= 1'b1;
		ray_box.origin_x <= it.origin_x;
		ray_box.origin_y <= it.origin_y;
		ray_box.dir_x <= it.dir_x;
		ray_box.dir_y <= it.dir_y;
		ray_box.max_distance <= it.max_distance;
		ray_box.center_x <= it.center_x;
		ray_box.center_y <= it.center_y;
		ray_box.right_axis_x <= it.right_axis_x;
		ray_box.right_axis_y <= it.right_axis_y;
		ray_box.half_width <= it.half_width;
		ray_box.half_height <= it.half_height;
		do @(posedge clk); while (!ray_box.ready);
		sb.note_item(it);
	endtask

	task automatic drain();
		ray_box.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_epsilon(logic [14:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.epsilon = value;
	endtask

	function automatic logic signed [15:0] unit_comp(real a, bit use_sin);
		return 16'($rtoi(16384.0 * (use_sin ? $sin(a) : $cos(a))));
	endfunction

	function automatic roi_pkg::item_t random_item();
		roi_pkg::item_t it;
		real a, b;
		int mode;
		mode = $urandom_range(99);
		it.origin_x = $urandom; it.origin_y = $urandom;
		it.dir_x = 16'($urandom); it.dir_y = 16'($urandom);
		it.max_distance = 31'($urandom); it.center_x = $urandom; it.center_y = $urandom;
		it.right_axis_x = 16'($urandom); it.right_axis_y = 16'($urandom);
		it.half_width = 31'($urandom); it.half_height = 31'($urandom);
		if (mode < 85) begin
			a = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
			b = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
			if ($urandom_range(4) == 0) a = $urandom_range(3) * 3.14159265358979 / 2.0;
			if ($urandom_range(4) == 0) b = $urandom_range(3) * 3.14159265358979 / 2.0;
			it.dir_x = unit_comp(a, 0); it.dir_y = unit_comp(a, 1);
			it.right_axis_x = unit_comp(b, 0); it.right_axis_y = unit_comp(b, 1);
			it.origin_x = $signed($urandom) >>> $urandom_range(4, 12);
			it.origin_y = $signed($urandom) >>> $urandom_range(4, 12);
			it.center_x = it.origin_x + ($signed($urandom) >>> $urandom_range(6, 14));
			it.center_y = it.origin_y + ($signed($urandom) >>> $urandom_range(6, 14));
			it.half_width = 31'($urandom >> $urandom_range(7, 16));
			it.half_height = 31'($urandom >> $urandom_range(7, 16));
			it.max_distance = ($urandom_range(9) == 0) ? 31'h7fffffff
				: 31'($urandom >> $urandom_range(3, 12));
		end
		return it;
	endfunction

	initial begin
		roi_pkg::item_t it;
		logic [14:0] eps_values[5];
		int sizes[5];
		eps_values = '{15'd1, 15'd0, 15'd16384, 15'd32767, 15'd0};
		eps_values[4] = 15'($urandom_range(1, 4000));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset epsilon.
		it = '0; send_item(it);
		it = '1; send_item(it);
		it = '{32'sh7fffffff, 32'sh80000000, 16'sh8000, 16'sh7fff, 31'h7fffffff,
			32'sh80000000, 32'sh7fffffff, 16'sh8000, 16'sh8000, 31'h7fffffff, 31'h7fffffff};
		send_item(it);
		it = '{32'sh80000000, 32'sh7fffffff, 16'sh7fff, 16'sh8000, 31'h7fffffff,
			32'sh7fffffff, 32'sh80000000, 16'sh7fff, 16'sh7fff, 31'h0, 31'h0};
		send_item(it);
		// Origin inside the box.
		it = '{0, 0, 16384, 0, 31'h100000, 32'sh8000, 0, 16384, 0, 31'h20000, 31'h20000};
		send_item(it);
		// Ray along +X hitting the -X face, then running parallel outside the Y slab.
		it = '{-32'sh50000, 0, 16384, 0, 31'h100000, 0, 0, 16384, 0, 31'h10000, 31'h10000};
		send_item(it);
		it.origin_y = 32'sh30000; send_item(it);
		// Ray along +Y toward the -Y face, a miss by direction, and out of range.
		it = '{0, -32'sh50000, 0, 16384, 31'h100000, 0, 0, 16384, 0, 31'h10000, 31'h10000};
		send_item(it);
		it.dir_y = -16384; send_item(it);
		it.dir_y = 16384; it.max_distance = 31'h20000; send_item(it);
		// Diagonal ray hits a 45 degree box head on; face ties go to the earlier face.
		it = '{-32'sh20000, -32'sh20000, 11585, 11585, 31'h100000, 0, 0,
			11585, 11585, 31'h10000, 31'h10000};
		send_item(it);
		// Rotated box, small direction components near the epsilon.
		it = '{-32'sh50000, 32'sh100, 16384, 1, 31'h7fffffff, 0, 0, 0, 16384, 31'h8000, 31'h8000};
		send_item(it);
		it.right_axis_x = -16384; it.right_axis_y = 0; send_item(it);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_epsilon(eps_values[ph]);
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 58; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 58; end
				default: begin send_idle = 21; recv_stall = 21; end
			endcase
			for (int i = 0; i < 340; i++) begin
				if (ph == 1 && i == 150) begin
					ray_box.valid <= 1'b0;
					@(posedge clk);
					while (sb.pending.size() != 0) @(posedge clk);
				end
				send_item(random_item());
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/roi_pkg.sv
rtl/core/roi_if.sv
rtl/core/roi_xform.sv
rtl/core/roi_divide.sv
rtl/core/roi_slab.sv
rtl/core/roi_hitpt.sv
rtl/core/ray_obb_intersect_2d_unit.sv
rtl/core/roi_checker.sv
dv/testbench.sv
